// File: hw/rtl/sv39_page_mapper_unit_defines.svh
// Assertion macros shared by the page mapper RTL.
`ifndef SV39_PAGE_MAPPER_UNIT_DEFINES_SVH
`define SV39_PAGE_MAPPER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define SPM_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle check");
// Next-cycle implication, disabled while reset is high.
`define SPM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle check");
`else
`define SPM_ASSERT_NOW(label, clk, rst, lhs, rhs)
`define SPM_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

// File: hw/rtl/spm_pkg.sv
// Package: widths, constants and sequencer states of the page mapper.
package spm_pkg;

   localparam int PPN_W      = 44;
   localparam int ENTRY_W    = 54;
   localparam int VA_W       = 39;
   localparam int PA_W       = 56;
   localparam int FLAG_W     = 10;
   localparam int VPN_W      = 9;
   localparam int PAGE_SHIFT = 12;
   localparam int PPN_LSB    = 10;

   localparam logic [PPN_W-1:0]  RESET_POOL_BASE = 44'h80200;
   localparam logic [FLAG_W-1:0] FLAG_VALID      = 10'h001;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_MAP   = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   localparam logic [1:0] LEVEL_TOP = 2'd2;
   localparam logic [1:0] LEVEL_MID = 2'd1;
   localparam logic [1:0] LEVEL_LEAF = 2'd0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_LEAF,
      ST_RESP
   } state_type;

endpackage

// File: hw/rtl/sv39_page_mapper_unit.sv
// Top level: page-table page pool and Sv39 mapper built around one entry memory.
// Sequence after accept: allocate goes straight to the response; a full map walk reads and
//   evaluates at levels 2 and 1, writes the leaf, then responds; a map can also fail early.
// One command word at a time: the next is accepted only after the response, back in idle.
// Reset: synchronous; a clearing pass over all POOL_PAGES*512 entries (32768) runs with busy high.
// The receiver cannot stall: each response shows for exactly one cycle.

`include "sv39_page_mapper_unit_defines.svh"

module sv39_page_mapper_unit #(
   parameter int POOL_PAGES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // command channel
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_mode,
   input  logic [5:0]                  req_root_page,
   input  logic [spm_pkg::VA_W-1:0]    req_virtual_address,
   input  logic [spm_pkg::PA_W-1:0]    req_physical_address,
   input  logic [spm_pkg::FLAG_W-1:0]  req_leaf_flags,
   // response channel
   output logic                        rsp_valid,
   output logic                        rsp_status,
   output logic [spm_pkg::PA_W-1:0]    rsp_page_address,
   output logic [1:0]                  rsp_tables_allocated,
   // configuration
   input  logic                        csr_we,
   input  logic [spm_pkg::PPN_W-1:0]   csr_wdata
);

   // Geometry. Each pool page is a table of 512 entries.
   localparam int TABLE_ENTRIES = 512;
   localparam int PAGE_W    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int CNT_W     = $clog2(POOL_PAGES + 1);
   localparam int SLOT_W    = PAGE_W + spm_pkg::VPN_W;
   localparam int MEM_DEPTH = POOL_PAGES * TABLE_ENTRIES;
   localparam int MEM_W     = spm_pkg::ENTRY_W + 1;   // entry plus page tag

   // Pages are never freed, so the pool fills from the bottom: the lowest
   // free page is always the allocation count, and page i is in use exactly
   // when i < alloc_cnt. Allocation clears a page logically: each stored
   // entry carries a tag bit, the in-use state of its page when written. An
   // entry whose tag disagrees with the page's current state reads as zero.
   // Since a page goes from free to used once, one tag bit is enough.

   spm_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]          alloc_cnt_ff, alloc_cnt_in;
   logic [spm_pkg::PPN_W-1:0] pool_base_ff;
   logic [SLOT_W-1:0]         clr_addr_ff, clr_addr_in;

   // latched command word
   logic                        mode_ff;
   logic [spm_pkg::VA_W-1:0]    va_ff;
   logic [spm_pkg::PA_W-1:0]    pa_ff;
   logic [spm_pkg::FLAG_W-1:0]  flags_ff;

   // walk state
   logic [PAGE_W-1:0] table_ff, table_in;
   logic [1:0]        level_ff, level_in;

   // response registers
   logic                      status_ff, status_in;
   logic [spm_pkg::PA_W-1:0]  addr_ff, addr_in;
   logic [1:0]                made_ff, made_in;

   // entry memory
   logic [MEM_W-1:0]  table_mem [MEM_DEPTH];
   logic [MEM_W-1:0]  rd_data_ff;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [MEM_W-1:0]  mem_wdata;
   logic [SLOT_W-1:0] slot;

   logic [spm_pkg::VPN_W-1:0]  vpn;
   logic                       table_used;
   logic                       entry_valid;
   logic [spm_pkg::PPN_W-1:0]  entry_ppn;
   logic [spm_pkg::PPN_W-1:0]  entry_off;
   logic [spm_pkg::PPN_W-1:0]  free_ppn;
   logic                       pool_full;
   logic [CNT_W-1:0]           alloc_next;

   // VPN of the current level
   always_comb begin
      case (level_ff)
         spm_pkg::LEVEL_TOP: vpn = va_ff[38:30];
         spm_pkg::LEVEL_MID: vpn = va_ff[29:21];
         default:            vpn = va_ff[20:12];
      endcase
   end

   assign slot        = {table_ff, vpn};
   assign table_used  = CNT_W'(table_ff) < alloc_cnt_ff;
   assign entry_valid = (rd_data_ff[spm_pkg::ENTRY_W] == table_used) && rd_data_ff[0];
   assign entry_ppn   = rd_data_ff[spm_pkg::ENTRY_W-1:spm_pkg::PPN_LSB];
   assign entry_off   = entry_ppn - pool_base_ff;
   assign free_ppn    = pool_base_ff + spm_pkg::PPN_W'(alloc_cnt_ff);
   assign pool_full   = alloc_cnt_ff >= CNT_W'(POOL_PAGES);
   assign alloc_next  = alloc_cnt_ff + CNT_W'(1);

   // Sequencer: next state, walk registers and memory write port.
   always_comb begin
      state_in     = state_ff;
      alloc_cnt_in = alloc_cnt_ff;
      clr_addr_in  = clr_addr_ff;
      table_in     = table_ff;
      level_in     = level_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      made_in      = made_ff;
      mem_we       = 1'b0;
      mem_waddr    = slot;
      mem_wdata    = '0;

      case (state_ff)
         spm_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + SLOT_W'(1);
            if (clr_addr_ff == SLOT_W'(MEM_DEPTH - 1)) begin
               state_in = spm_pkg::ST_IDLE;
            end
         end

         spm_pkg::ST_IDLE: begin
            if (start) begin
               status_in = spm_pkg::STATUS_OK;
               addr_in   = '0;
               made_in   = '0;
               table_in  = PAGE_W'(req_root_page);
               level_in  = spm_pkg::LEVEL_TOP;
               if (req_mode == spm_pkg::MODE_ALLOC) begin
                  state_in = spm_pkg::ST_RESP;
                  if (pool_full) begin
                     status_in = spm_pkg::STATUS_FAIL;
                  end else begin
                     addr_in      = {free_ppn, {spm_pkg::PAGE_SHIFT{1'b0}}};
                     alloc_cnt_in = alloc_next;
                  end
               end else if (32'(req_root_page) >= 32'(POOL_PAGES)) begin
                  status_in = spm_pkg::STATUS_FAIL;
                  state_in  = spm_pkg::ST_RESP;
               end else begin
                  state_in = spm_pkg::ST_READ;
               end
            end
         end

         spm_pkg::ST_READ: begin
            state_in = spm_pkg::ST_EVAL;   // read data lands next cycle
         end

         spm_pkg::ST_EVAL: begin
            if (entry_valid) begin
               if (entry_off >= spm_pkg::PPN_W'(POOL_PAGES)) begin
                  status_in = spm_pkg::STATUS_FAIL;
                  state_in  = spm_pkg::ST_RESP;
               end else begin
                  table_in = entry_off[PAGE_W-1:0];
                  state_in = (level_ff == spm_pkg::LEVEL_MID) ? spm_pkg::ST_LEAF
                                                              : spm_pkg::ST_READ;
               end
            end else if (pool_full) begin
               status_in = spm_pkg::STATUS_FAIL;
               state_in  = spm_pkg::ST_RESP;
            end else begin
               // link a fresh table; tag with the state after this allocation,
               // which matters when the walk's own table is the page taken
               mem_we       = 1'b1;
               mem_wdata    = {CNT_W'(table_ff) < alloc_next, free_ppn,
                               spm_pkg::FLAG_VALID};
               alloc_cnt_in = alloc_next;
               made_in      = made_ff + 2'd1;
               table_in     = alloc_cnt_ff[PAGE_W-1:0];
               state_in     = (level_ff == spm_pkg::LEVEL_MID) ? spm_pkg::ST_LEAF
                                                               : spm_pkg::ST_READ;
            end
            level_in = level_ff - 2'd1;
         end

         spm_pkg::ST_LEAF: begin
            mem_we    = 1'b1;
            mem_wdata = {table_used, pa_ff[spm_pkg::PA_W-1:spm_pkg::PAGE_SHIFT],
                         flags_ff | spm_pkg::FLAG_VALID};
            state_in  = spm_pkg::ST_RESP;
         end

         spm_pkg::ST_RESP: begin
            state_in = spm_pkg::ST_IDLE;
         end

         default: begin
            state_in = spm_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spm_pkg::ST_CLEAR;
         alloc_cnt_ff <= '0;
         clr_addr_ff  <= '0;
         pool_base_ff <= spm_pkg::RESET_POOL_BASE;
      end else begin
         state_ff     <= state_in;
         alloc_cnt_ff <= alloc_cnt_in;
         clr_addr_ff  <= clr_addr_in;
         if (csr_we) begin
            pool_base_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      table_ff  <= table_in;
      level_ff  <= level_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
      made_ff   <= made_in;
      if (state_ff == spm_pkg::ST_IDLE && start) begin
         mode_ff  <= req_mode;
         va_ff    <= req_virtual_address;
         pa_ff    <= req_physical_address;
         flags_ff <= req_leaf_flags;
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[slot];
   end

   assign busy                 = state_ff != spm_pkg::ST_IDLE;
   assign rsp_valid            = state_ff == spm_pkg::ST_RESP;
   assign rsp_status           = status_ff;
   assign rsp_page_address     = addr_ff;
   assign rsp_tables_allocated = made_ff;

   // assertions
   `SPM_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `SPM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `SPM_ASSERT_NOW(a_pool_bound, clock, reset, 1'b1, alloc_cnt_ff <= CNT_W'(POOL_PAGES))
   `SPM_ASSERT_NOW(a_alloc_no_tables, clock, reset,
      rsp_valid && mode_ff == spm_pkg::MODE_ALLOC, rsp_tables_allocated == 2'd0)

endmodule
